// ===== hw/rtl/fpd_pkg.sv =====
// types and constants shared by the flight phase detector
`default_nettype none

package fpd_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] REG_JUMP_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_TREND_LIMIT    = 2'd1;
  localparam logic [1:0] REG_GRAVITY_LEVEL  = 2'd2;
  localparam logic [1:0] REG_ACCEL_BAND     = 2'd3;

  localparam logic [19:0] JUMP_THRESHOLD_RST = 20'd1000;
  localparam logic [7:0]  TREND_LIMIT_RST    = 8'd10;
  localparam logic [18:0] GRAVITY_LEVEL_RST  = 19'd9807;
  localparam logic [18:0] ACCEL_BAND_RST     = 19'd1000;

  localparam logic [8:0] COUNT_MAX  = 9'd511;
  localparam logic [1:0] JUMP_STEP  = 2'd3;
  localparam logic [1:0] SMALL_STEP = 2'd1;

  typedef enum logic [1:0] {
    TR_STATIONARY = 2'd0,
    TR_RISING     = 2'd1,
    TR_FALLING    = 2'd2
  } trend_e;

  typedef enum logic [2:0] {
    ACC_NEAR_ZERO = 3'd0,
    ACC_NEAR_G    = 3'd1,
    ACC_HIGH_POS  = 3'd2,
    ACC_LOW_NEG   = 3'd3,
    ACC_HIGH_NEG  = 3'd4
  } accel_e;

  typedef enum logic [3:0] {
    PH_STABILIZE   = 4'd0,
    PH_READY       = 4'd1,
    PH_POWERED     = 4'd2,
    PH_COASTING    = 4'd3,
    PH_FREEFALL    = 4'd4,
    PH_CHUTE_DECEL = 4'd5,
    PH_TERMINAL    = 4'd6,
    PH_LANDED      = 4'd7,
    PH_UNKNOWN     = 4'd8
  } phase_e;

  typedef struct packed {
    logic        baro_due;
    logic [31:0] altitude_mm;
    logic [19:0] accel_mm;
    logic        parachute_deployed;
    logic        stable;
  } fpd_in_t;

  typedef struct packed {
    phase_e flight_phase;
    trend_e altitude_trend;
    accel_e accel_class;
  } fpd_out_t;

  typedef struct packed {
    logic [19:0] jump_threshold;
    logic [7:0]  trend_limit;
    logic [18:0] gravity_level;
    logic [18:0] accel_band;
  } fpd_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpd_cfg.sv =====
// configuration register file behind the apb port
`default_nettype none

module fpd_cfg
  import fpd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output fpd_cfg_t              cfg_o
);

  fpd_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_threshold <= JUMP_THRESHOLD_RST;
      cfg_q.trend_limit    <= TREND_LIMIT_RST;
      cfg_q.gravity_level  <= GRAVITY_LEVEL_RST;
      cfg_q.accel_band     <= ACCEL_BAND_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_JUMP_THRESHOLD: cfg_q.jump_threshold <= pwdata[19:0];
        REG_TREND_LIMIT:    cfg_q.trend_limit    <= pwdata[7:0];
        REG_GRAVITY_LEVEL:  cfg_q.gravity_level  <= pwdata[18:0];
        REG_ACCEL_BAND:     cfg_q.accel_band     <= pwdata[18:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_JUMP_THRESHOLD: prdata = {12'd0, cfg_q.jump_threshold};
      REG_TREND_LIMIT:    prdata = {24'd0, cfg_q.trend_limit};
      REG_GRAVITY_LEVEL:  prdata = {13'd0, cfg_q.gravity_level};
      REG_ACCEL_BAND:     prdata = {13'd0, cfg_q.accel_band};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpd_baro.sv =====
// altitude trend tracking: previous sample, fall and rise counters, held trend
`default_nettype none

module fpd_baro
  import fpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        upd_en_i,
  input  wire logic        baro_due_i,
  input  wire logic [31:0] altitude_i,
  input  fpd_cfg_t         cfg_i,
  output trend_e           trend_o
);

  logic signed [31:0] prev_q;
  logic        [8:0]  fall_q;
  logic        [8:0]  rise_q;
  trend_e             trend_q;

  logic signed [32:0] alt_ext;
  logic signed [32:0] old_ext;
  logic signed [32:0] jmp_ext;
  logic signed [32:0] fall_diff;
  logic signed [32:0] rise_diff;
  logic        [9:0]  fall_sum;
  logic        [9:0]  rise_sum;
  logic        [8:0]  fall_cnt;
  logic        [8:0]  rise_cnt;
  logic        [8:0]  fall_d;
  logic        [8:0]  rise_d;
  trend_e             trend_d;
  logic        [8:0]  limit;
  logic               upd;

  assign upd     = upd_en_i && baro_due_i;
  assign alt_ext = {altitude_i[31], altitude_i};
  assign old_ext = {prev_q[31], prev_q};
  assign jmp_ext = {13'd0, cfg_i.jump_threshold};
  assign limit   = {1'b0, cfg_i.trend_limit};

  always_comb begin
    fall_diff = old_ext - alt_ext;
    rise_diff = alt_ext - old_ext;

    // saturating counter steps
    if (fall_diff >= jmp_ext) begin
      fall_sum = {1'b0, fall_q} + {8'd0, JUMP_STEP};
    end else if (fall_diff > 33'sd0) begin
      fall_sum = {1'b0, fall_q} + {8'd0, SMALL_STEP};
    end else begin
      fall_sum = '0;
    end
    if (rise_diff >= jmp_ext) begin
      rise_sum = {1'b0, rise_q} + {8'd0, JUMP_STEP};
    end else if (rise_diff > 33'sd0) begin
      rise_sum = {1'b0, rise_q} + {8'd0, SMALL_STEP};
    end else begin
      rise_sum = '0;
    end
    fall_cnt = (fall_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : fall_sum[8:0];
    rise_cnt = (rise_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : rise_sum[8:0];

    // falling wins when both reach the limit
    fall_d = fall_cnt;
    rise_d = rise_cnt;
    priority if (fall_cnt >= limit) begin
      trend_d = TR_FALLING;
      fall_d  = '0;
    end else if (rise_cnt >= limit) begin
      trend_d = TR_RISING;
      rise_d  = '0;
    end else begin
      trend_d = TR_STATIONARY;
    end
  end

  assign trend_o = baro_due_i ? trend_d : trend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      fall_q  <= '0;
      rise_q  <= '0;
      trend_q <= TR_STATIONARY;
    end else if (upd) begin
      prev_q  <= altitude_i;
      fall_q  <= fall_d;
      rise_q  <= rise_d;
      trend_q <= trend_d;
    end
  end

`ifndef SYNTHESIS
  a_counters_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fall_q != 9'd0 && rise_q != 9'd0))
    else $error("fall and rise counters both nonzero");

  a_fall_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && trend_d == TR_FALLING |=> fall_q == 9'd0 && trend_q == TR_FALLING)
    else $error("fall counter not cleared on falling");

  a_rise_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && trend_d == TR_RISING |=> rise_q == 9'd0 && trend_q == TR_RISING)
    else $error("rise counter not cleared on rising");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fpd_decode.sv =====
// acceleration banding and flight phase priority decode
`default_nettype none

module fpd_decode
  import fpd_pkg::*;
(
  input  wire logic [19:0] accel_mm_i,
  input  wire logic        chute_i,
  input  wire logic        stable_i,
  input  trend_e           trend_i,
  input  fpd_cfg_t         cfg_i,
  output fpd_out_t         res_o
);

  logic signed [21:0] acc;
  logic signed [21:0] band;
  logic signed [21:0] grav;
  logic signed [21:0] neg_band;
  logic signed [21:0] band_m_g;
  logic signed [21:0] neg_g_m_band;
  accel_e             cls;
  phase_e             phase;

  assign acc          = {{2{accel_mm_i[19]}}, accel_mm_i};
  assign band         = {3'd0, cfg_i.accel_band};
  assign grav         = {3'd0, cfg_i.gravity_level};
  assign neg_band     = -band;
  assign band_m_g     = band - grav;
  assign neg_g_m_band = neg_band - grav;

  always_comb begin
    priority if (acc <= band && acc >= neg_band) begin
      cls = ACC_NEAR_ZERO;
    end else if (acc <= band_m_g && acc >= neg_g_m_band) begin
      cls = ACC_NEAR_G;
    end else if (acc > band) begin
      cls = ACC_HIGH_POS;
    end else if (acc <= neg_band && acc >= band_m_g) begin
      cls = ACC_LOW_NEG;
    end else begin
      cls = ACC_HIGH_NEG;
    end
  end

  always_comb begin
    priority if (!chute_i && trend_i == TR_STATIONARY && cls == ACC_NEAR_ZERO) begin
      phase = stable_i ? PH_READY : PH_STABILIZE;
    end else if (!chute_i && stable_i && trend_i == TR_RISING && cls == ACC_HIGH_POS) begin
      phase = PH_POWERED;
    end else if (!chute_i && stable_i && trend_i == TR_RISING &&
                 (cls == ACC_NEAR_G || cls == ACC_LOW_NEG)) begin
      phase = PH_COASTING;
    end else if (!chute_i && stable_i && trend_i == TR_FALLING && cls == ACC_NEAR_G) begin
      phase = PH_FREEFALL;
    end else if (chute_i && stable_i && trend_i == TR_FALLING && cls == ACC_LOW_NEG) begin
      phase = PH_CHUTE_DECEL;
    end else if (chute_i && stable_i && trend_i == TR_FALLING && cls == ACC_NEAR_ZERO) begin
      phase = PH_TERMINAL;
    end else if (chute_i && stable_i && trend_i == TR_STATIONARY && cls == ACC_NEAR_ZERO) begin
      phase = PH_LANDED;
    end else begin
      phase = PH_UNKNOWN;
    end
  end

  assign res_o.flight_phase   = phase;
  assign res_o.altitude_trend = trend_i;
  assign res_o.accel_class    = cls;

endmodule

`default_nettype wire

// ===== hw/rtl/flight_phase_detector_top.sv =====
// flight phase detector top level: input register, trend and decode logic, result register
//
// usage
//   input channel in_valid_i / in_ready_o carries one sensor tick per transfer:
//   barometer flag, altitude in mm, filtered vertical acceleration in mm/s^2,
//   parachute pin and stability bit
//   output channel out_valid_o / out_ready_i returns one result per tick:
//   flight phase, altitude trend and acceleration class
//   configuration through the apb port (jump threshold, trend limit,
//   gravity level, accel band at byte addresses 0, 4, 8, 12); pready is always high
//   a taken tick waits in the input register; its result is decoded combinationally
//   and loaded, with out_valid_o set, once the result register is empty or being taken
//   throughput: one tick per cycle unless out_ready_i stalls the single register pair
//   a stalled receiver holds the result register; one more tick waits in the
//   input register, then in_ready_o drops until the result is taken
//   reset clears both valid flags, the previous altitude, both counters and
//   the held trend, and loads the register defaults
`default_nettype none

module flight_phase_detector_top
  import fpd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  fpd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output fpd_out_t              out_data_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  fpd_in_t  in_q;
  logic     in_valid_q;
  logic     in_valid_d;
  fpd_out_t out_q;
  logic     out_valid_q;
  logic     out_valid_d;
  logic     advance;
  fpd_cfg_t cfg;
  trend_e   trend;
  fpd_out_t res;

  fpd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fpd_baro u_baro (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_en_i   (advance),
    .baro_due_i (in_q.baro_due),
    .altitude_i (in_q.altitude_mm),
    .cfg_i      (cfg),
    .trend_o    (trend)
  );

  fpd_decode u_decode (
    .accel_mm_i (in_q.accel_mm),
    .chute_i    (in_q.parachute_deployed),
    .stable_i   (in_q.stable),
    .trend_i    (trend),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("pending tick lost from input register");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o && out_data_o == $past(res))
    else $error("result register not loaded on advance");

  a_powered_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.flight_phase == PH_POWERED |->
      out_data_o.altitude_trend == TR_RISING && out_data_o.accel_class == ACC_HIGH_POS)
    else $error("powered phase without rising trend and high positive accel");
`endif

endmodule

`default_nettype wire
